// ----- design/cfd_pkg.sv -----
package cfd_pkg;

  localparam logic [7:0]  SYNC_HI  = 8'hAA;
  localparam logic [7:0]  SYNC_LO  = 8'h55;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned OVHD_BYTES = 10;
  localparam int unsigned LEN_W      = 6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       clear_buffer;
  } cfd_in_t;

  typedef struct packed {
    logic             frame_out;
    logic [7:0]       frame_type;
    logic [7:0]       frame_sequence;
    logic [7:0]       frame_flags;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic             last;
    logic [31:0]      format_error_count;
    logic [31:0]      crc_error_count;
  } cfd_out_t;

  // one queued frame word, counters and last are added on the way out
  typedef struct packed {
    logic [7:0]       frame_type;
    logic [7:0]       frame_sequence;
    logic [7:0]       frame_flags;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
  } cfd_entry_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/crc16_frame_stream_deframer.sv -----
// channel | dir | handshake                  | word
// in      | in  | in_valid_i / in_stall_o    | cfd_in_t: rx_byte, clear_buffer
// out     | out | out_valid_o / out_stall_i  | cfd_out_t: frame fields and counters
// cfg     | in  | cfg_valid_i / cfg_ready_o  | protocol_version
//
// one input word at a time: the buffer memory has a single read port with a
// registered read, so every buffered byte touched takes an address phase and
// then a data phase; a new byte is scanned for a sync pair, then the header and
// frame are checked once enough bytes wait, and each result word is read from
// the result queue before it is offered
// reset clears fill count, counters and sequencer; version resets to 1
// out_stall_i holds the current result word; in_stall_o is high while busy
module crc16_frame_stream_deframer #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfd_pkg::cfd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfd_pkg::cfd_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import cfd_pkg::*;

  localparam int unsigned DEPTH = OVHD_BYTES + MAX_PAYLOAD;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = FW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_VER     = 4'd2;
  localparam logic [3:0] S_LEN_LO  = 4'd3;
  localparam logic [3:0] S_LEN_HI  = 4'd4;
  localparam logic [3:0] S_CRC     = 4'd5;
  localparam logic [3:0] S_CRC_LO  = 4'd6;
  localparam logic [3:0] S_CRC_HI  = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;
  localparam logic [3:0] S_OUT_RD  = 4'd9;
  localparam logic [3:0] S_OUT_WR  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    off_q, off_d;
  logic             ph_q, ph_d;
  logic             prev_aa_q, prev_aa_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       exp_lo_q, exp_lo_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       seq_q, seq_d;
  logic [7:0]       flags_q, flags_d;
  logic [31:0]      fmt_q, fmt_d;
  logic [31:0]      crce_q, crce_d;
  logic [7:0]       ver_q;
  logic [FW-1:0]    rc_q, rc_d;
  logic [FW-1:0]    k_q, k_d;

  // byte buffer, circular from head_q
  logic [7:0]    buf_mem [DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;

  logic          crc_init, crc_en;
  logic [15:0]   crc_val;

  logic          res_we;
  cfd_entry_t    res_wdata, res_rdata;

  logic [FW-1:0] frame_len;
  logic          full;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    if (s >= SW'(DEPTH)) begin
      return AW'(s - SW'(DEPTH));
    end
    return AW'(s);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  assign full      = (fill_q == FW'(DEPTH));
  assign wr_addr   = wrap(SW'(head_q) + SW'(fill_q));
  assign rd_addr   = wrap(SW'(head_q) + SW'(off_q));
  assign frame_len = FW'(OVHD_BYTES) + FW'(len_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    off_d     = off_q;
    ph_d      = ph_q;
    prev_aa_d = prev_aa_q;
    len_lo_d  = len_lo_q;
    len_d     = len_q;
    exp_lo_d  = exp_lo_q;
    type_d    = type_q;
    seq_d     = seq_q;
    flags_d   = flags_q;
    fmt_d     = fmt_q;
    crce_d    = crce_q;
    rc_d      = rc_q;
    k_d       = k_q;
    mem_we    = 1'b0;
    crc_init  = 1'b0;
    crc_en    = 1'b0;
    res_we    = 1'b0;
    res_wdata = '{frame_type: type_q, frame_sequence: seq_q, frame_flags: flags_q,
                  payload_length: len_q, payload_byte: rd_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rc_d = '0;
          k_d  = '0;
          if (in_data_i.clear_buffer) begin
            fill_d  = '0;
            state_d = S_OUT_RD;
          end else begin
            mem_we = 1'b1;
            // full store drops its oldest byte
            if (full) begin
              head_d = wrap(SW'(head_q) + SW'(1));
            end else begin
              fill_d = fill_q + FW'(1);
            end
            off_d     = '0;
            ph_d      = 1'b0;
            prev_aa_d = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!ph_q) begin
          if (off_q == fill_q) begin
            // no sync pair: keep only a trailing sync high byte
            if (prev_aa_q) begin
              head_d = wrap(SW'(head_q) + SW'(fill_q) - SW'(1));
              fill_d = FW'(1);
            end else begin
              fill_d = '0;
            end
            state_d = S_OUT_RD;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          ph_d = 1'b0;
          if (prev_aa_q && rd_q == SYNC_LO) begin
            head_d  = wrap(SW'(head_q) + SW'(off_q) - SW'(1));
            fill_d  = fill_q - (off_q - FW'(1));
            off_d   = FW'(2);
            state_d = S_VER;
          end else begin
            prev_aa_d = (rd_q == SYNC_HI);
            off_d     = off_q + FW'(1);
          end
        end
      end

      S_VER: begin
        if (!ph_q) begin
          if (fill_q < FW'(HDR_BYTES)) begin
            state_d = S_OUT_RD;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          ph_d = 1'b0;
          if (rd_q != ver_q) begin
            fmt_d     = sat_inc(fmt_q);
            head_d    = wrap(SW'(head_q) + SW'(1));
            fill_d    = fill_q - FW'(1);
            off_d     = '0;
            prev_aa_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            off_d   = FW'(6);
            state_d = S_LEN_LO;
          end
        end
      end

      S_LEN_LO: begin
        ph_d = !ph_q;
        if (ph_q) begin
          len_lo_d = rd_q;
          off_d    = FW'(7);
          state_d  = S_LEN_HI;
        end
      end

      S_LEN_HI: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if ({rd_q, len_lo_q} > 16'(MAX_PAYLOAD)) begin
            fmt_d     = sat_inc(fmt_q);
            head_d    = wrap(SW'(head_q) + SW'(1));
            fill_d    = fill_q - FW'(1);
            off_d     = '0;
            prev_aa_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            len_d = len_lo_q[LEN_W-1:0];
            if (SW'(fill_q) < SW'(OVHD_BYTES) + SW'(len_lo_q[LEN_W-1:0])) begin
              state_d = S_OUT_RD;
            end else begin
              crc_init = 1'b1;
              off_d    = FW'(2);
              state_d  = S_CRC;
            end
          end
        end
      end

      S_CRC: begin
        ph_d = !ph_q;
        if (ph_q) begin
          crc_en = 1'b1;
          if (off_q == FW'(3)) type_d  = rd_q;
          if (off_q == FW'(4)) seq_d   = rd_q;
          if (off_q == FW'(5)) flags_d = rd_q;
          off_d = off_q + FW'(1);
          if (off_q == FW'(7) + FW'(len_q)) begin
            state_d = S_CRC_LO;
          end
        end
      end

      S_CRC_LO: begin
        ph_d = !ph_q;
        if (ph_q) begin
          exp_lo_d = rd_q;
          off_d    = off_q + FW'(1);
          state_d  = S_CRC_HI;
        end
      end

      S_CRC_HI: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if ({rd_q, exp_lo_q} != crc_val) begin
            crce_d    = sat_inc(crce_q);
            head_d    = wrap(SW'(head_q) + SW'(1));
            fill_d    = fill_q - FW'(1);
            off_d     = '0;
            prev_aa_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            off_d   = FW'(HDR_BYTES);
            state_d = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (len_q == '0 || ph_q) begin
          ph_d = 1'b0;
          if (len_q == '0) begin
            res_wdata.payload_byte = 8'h00;
          end
          // results beyond the queue depth are dropped
          if (rc_q != FW'(DEPTH)) begin
            res_we = 1'b1;
            rc_d   = rc_q + FW'(1);
          end
          if (len_q == '0 || off_q == FW'(7) + FW'(len_q)) begin
            head_d    = wrap(SW'(head_q) + SW'(frame_len));
            fill_d    = fill_q - frame_len;
            off_d     = '0;
            prev_aa_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            off_d = off_q + FW'(1);
          end
        end else begin
          ph_d = 1'b1;
        end
      end

      S_OUT_RD: begin
        state_d = S_OUT_WR;
      end

      S_OUT_WR: begin
        if (!out_stall_i) begin
          if (rc_q == '0 || k_q == rc_q - FW'(1)) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + FW'(1);
            state_d = S_OUT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      off_q     <= '0;
      ph_q      <= 1'b0;
      prev_aa_q <= 1'b0;
      fmt_q     <= '0;
      crce_q    <= '0;
      rc_q      <= '0;
      k_q       <= '0;
      ver_q     <= 8'd1;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      off_q     <= off_d;
      ph_q      <= ph_d;
      prev_aa_q <= prev_aa_d;
      fmt_q     <= fmt_d;
      crce_q    <= crce_d;
      rc_q      <= rc_d;
      k_q       <= k_d;
      if (cfg_valid_i) begin
        ver_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    len_lo_q <= len_lo_d;
    len_q    <= len_d;
    exp_lo_q <= exp_lo_d;
    type_q   <= type_d;
    seq_q    <= seq_d;
    flags_q  <= flags_d;
  end

  // buffer memory, single read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      buf_mem[wr_addr] <= in_data_i.rx_byte;
    end
    rd_q <= buf_mem[rd_addr];
  end

  cfd_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (crc_init),
    .en_i   (crc_en),
    .data_i (rd_q),
    .crc_o  (crc_val)
  );

  cfd_result_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .wr_en_i   (res_we),
    .wr_addr_i (rc_q[AW-1:0]),
    .wr_data_i (res_wdata),
    .rd_addr_i (k_q[AW-1:0]),
    .rd_data_o (res_rdata)
  );

  // result word, counters are final by the time output starts
  always_comb begin
    if (rc_q == '0) begin
      out_data_o = '0;
      out_data_o.last = 1'b1;
    end else begin
      out_data_o.frame_out      = 1'b1;
      out_data_o.frame_type     = res_rdata.frame_type;
      out_data_o.frame_sequence = res_rdata.frame_sequence;
      out_data_o.frame_flags    = res_rdata.frame_flags;
      out_data_o.payload_length = res_rdata.payload_length;
      out_data_o.payload_byte   = res_rdata.payload_byte;
      out_data_o.last           = (k_q == rc_q - FW'(1));
    end
    out_data_o.format_error_count = fmt_q;
    out_data_o.crc_error_count    = crce_q;
  end

  assign out_valid_o = (state_q == S_OUT_WR);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

endmodule

// ----- design/cfd_crc_unit.sv -----
module cfd_crc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  logic        en_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import cfd_pkg::*;

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (init_i) begin
      crc_d = CRC_INIT;
    end else if (en_i) begin
      crc_d = crc_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ----- design/cfd_result_queue.sv -----
module cfd_result_queue #(
  parameter int unsigned DEPTH = 42
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  cfd_pkg::cfd_entry_t       wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  output cfd_pkg::cfd_entry_t       rd_data_o
);
  import cfd_pkg::*;

  cfd_entry_t mem [DEPTH];
  cfd_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ----- verif/tb_crc16_frame_stream_deframer.sv -----
`timescale 1ns / 100ps

module tb_crc16_frame_stream_deframer;
  import cfd_pkg::*;

  localparam int unsigned MAX_PL = 32;
  localparam int unsigned DEPTH  = 10 + MAX_PL;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  cfd_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  cfd_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i;

  crc16_frame_stream_deframer #(.MAX_PAYLOAD(MAX_PL)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // predictor state, mirrors the block
  logic [7:0]  buf_q[$];
  logic [31:0] fmt_errs;
  logic [31:0] crc_errs;
  logic [7:0]  version;

  cfd_out_t expected_words[$];
  int errors;
  int words_seen;
  int frames_seen;
  int bytes_sent;
  int send_idle_pct;
  int recv_stall_pct;

  function automatic logic [15:0] crc_over(int start, int len);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < len; i++) begin
      c = c ^ {buf_q[start + i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void sat_inc(ref logic [31:0] c);
    if (c != 32'hFFFF_FFFF) c = c + 32'd1;
  endfunction

  // works out every result word one input word causes
  task automatic predict_word(input cfd_in_t w);
    cfd_out_t step_q[$];
    cfd_out_t r;
    int i;
    int len;
    int cnt;
    bit found;
    bit keep;
    if (w.clear_buffer) begin
      buf_q.delete();
    end else begin
      if (buf_q.size() >= DEPTH) void'(buf_q.pop_front());
      buf_q = {buf_q, w.rx_byte};
      forever begin
        found = 0;
        for (i = 0; i + 1 < buf_q.size(); i++) begin
          if (buf_q[i] == 8'hAA && buf_q[i+1] == 8'h55) begin
            found = 1;
            break;
          end
        end
        if (!found) begin
          keep = buf_q.size() > 0 && buf_q[buf_q.size()-1] == 8'hAA;
          buf_q.delete();
          if (keep) buf_q = {buf_q, 8'hAA};
          break;
        end
        repeat (i) void'(buf_q.pop_front());
        if (buf_q.size() < 8) break;
        if (buf_q[2] != version) begin
          sat_inc(fmt_errs);
          void'(buf_q.pop_front());
          continue;
        end
        len = int'({buf_q[7], buf_q[6]});
        if (len > MAX_PL) begin
          sat_inc(fmt_errs);
          void'(buf_q.pop_front());
          continue;
        end
        if (buf_q.size() < 10 + len) break;
        if ({buf_q[9+len], buf_q[8+len]} != crc_over(2, 6 + len)) begin
          sat_inc(crc_errs);
          void'(buf_q.pop_front());
          continue;
        end
        cnt = len ? len : 1;
        for (int j = 0; j < cnt && step_q.size() < DEPTH; j++) begin
          r = '0;
          r.frame_out      = 1'b1;
          r.frame_type     = buf_q[3];
          r.frame_sequence = buf_q[4];
          r.frame_flags    = buf_q[5];
          r.payload_length = len[5:0];
          r.payload_byte   = len ? buf_q[8+j] : 8'h00;
          step_q = {step_q, r};
        end
        repeat (10 + len) void'(buf_q.pop_front());
      end
    end
    // status only word when no frame completed
    if (step_q.size() == 0) begin
      r = '0;
      step_q = {step_q, r};
    end
    foreach (step_q[k]) begin
      step_q[k].last = (k == step_q.size() - 1);
      step_q[k].format_error_count = fmt_errs;
      step_q[k].crc_error_count = crc_errs;
      expected_words = {expected_words, step_q[k]};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch word %0d %s: got %0h want %0h", words_seen, what, got, want);
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    cfd_out_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 32'd0, 32'd0);
        end else begin
          e = expected_words.pop_front();
          if (out_data_o.frame_out != e.frame_out)
            report_mismatch("frame_out", 32'(out_data_o.frame_out), 32'(e.frame_out));
          if (out_data_o.frame_type != e.frame_type)
            report_mismatch("frame_type", 32'(out_data_o.frame_type), 32'(e.frame_type));
          if (out_data_o.frame_sequence != e.frame_sequence)
            report_mismatch("frame_sequence", 32'(out_data_o.frame_sequence),
                            32'(e.frame_sequence));
          if (out_data_o.frame_flags != e.frame_flags)
            report_mismatch("frame_flags", 32'(out_data_o.frame_flags),
                            32'(e.frame_flags));
          if (out_data_o.payload_length != e.payload_length)
            report_mismatch("payload_length", 32'(out_data_o.payload_length),
                            32'(e.payload_length));
          if (out_data_o.payload_byte != e.payload_byte)
            report_mismatch("payload_byte", 32'(out_data_o.payload_byte),
                            32'(e.payload_byte));
          if (out_data_o.last != e.last)
            report_mismatch("last", 32'(out_data_o.last), 32'(e.last));
          if (out_data_o.format_error_count != e.format_error_count)
            report_mismatch("format_error_count", out_data_o.format_error_count,
                            e.format_error_count);
          if (out_data_o.crc_error_count != e.crc_error_count)
            report_mismatch("crc_error_count", out_data_o.crc_error_count,
                            e.crc_error_count);
          if (e.frame_out && e.last) frames_seen++;
        end
        words_seen++;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // one input word, held until accepted; valid drops only in an idle gap
  task automatic send_word(input logic [7:0] b, input logic clr);
    cfd_in_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    w.rx_byte = b;
    w.clear_buffer = clr;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(b, 1'b0);
  endtask

  function automatic logic [15:0] crc_byte_tb(logic [15:0] c, logic [7:0] d);
    c = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  // builds and sends one frame; bad_crc corrupts the check bytes
  task automatic send_frame(input logic [7:0] ver, input int len, input bit bad_crc);
    logic [7:0] f[$];
    logic [15:0] c;
    f = {8'hAA, 8'h55, ver, 8'($urandom), 8'($urandom), 8'($urandom),
         8'(len), 8'(len >> 8)};
    for (int i = 0; i < len; i++) f = {f, 8'($urandom)};
    c = 16'hFFFF;
    for (int i = 2; i < f.size(); i++) c = crc_byte_tb(c, f[i]);
    if (bad_crc) c = c ^ (16'h1 << $urandom_range(15));
    f = {f, c[7:0]};
    f = {f, c[15:8]};
    foreach (f[i]) send_byte(f[i]);
  endtask

  // waits for all results, then lets the block settle before a register write
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    version = v;
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  task automatic test_directed();
    send_frame(8'h01, 0, 0);           // empty payload at reset version
    send_frame(8'h01, MAX_PL, 0);      // largest payload
    send_frame(8'h01, 3, 1);           // checksum mismatch
    send_frame(8'h02, 2, 0);           // wrong version
    send_byte(8'hAA); send_byte(8'h55); send_byte(8'h01); send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); // oversize length
    send_byte(8'hAA);                  // lone trailing sync byte kept
    send_word(8'h55, 1'b1);            // clear discards it
    send_byte(8'h00);
  endtask

  task automatic test_version(input logic [7:0] v, input int frames);
    write_version(v);
    for (int i = 0; i < frames; i++) begin
      case ($urandom_range(9))
        0: send_byte(8'($urandom));
        1: send_word(8'($urandom), 1'b1);
        2: send_frame(8'($urandom), $urandom_range(4), 0);
        3: send_frame(v, $urandom_range(3), 1);
        4: begin
          send_byte(8'hAA); send_byte(8'h55); send_byte(v);
          repeat (3) send_byte(8'($urandom));
          send_byte(8'($urandom)); send_byte(8'($urandom_range(255, 1)));
        end
        5: send_frame(v, $urandom_range(MAX_PL), 0);
        default: send_frame(v, $urandom_range(4), 0);
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 8'h00;
    errors = 0;
    words_seen = 0;
    frames_seen = 0;
    bytes_sent = 0;
    fmt_errs = 0;
    crc_errs = 0;
    version = 8'h01;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_idling(0, 0);   test_version(8'h00, 5);
    set_idling(78, 0);  test_version(8'hFF, 5);
    set_idling(0, 78);  test_version(8'h5A, 5);
    set_idling(33, 33); test_version(8'h01, 5);
    set_idling(0, 0);   test_version(8'hA5, 2);

    drain();
    $display("sent %0d input words, checked %0d result words, %0d frames",
             bytes_sent, words_seen, frames_seen);
    $display("versions 0x00..0xff, good, bad checksum, bad version, oversize, clears");
    if (errors == 0) begin
      $display("crc16_frame_stream_deframer verification clean");
    end else begin
      $display("crc16_frame_stream_deframer verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("crc16_frame_stream_deframer verification failed");
    $finish;
  end

endmodule
